// ----- src/sdc_pkg.sv -----
`default_nettype none

package sdc_pkg;

  // Table geometry. The table holds one entry for each index below TABLE_SIZE.
  localparam int TABLE_SIZE = 524288;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = IDX_W + 1;
  localparam int FAC_W      = IDX_W;
  localparam int VAL_W      = 20;
  localparam int COUNT_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int EXP_W      = $clog2(IDX_W + 2);
  localparam int STEP_W     = $clog2(IDX_W);

  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;

  // Running product of (exponent + 1), saturating at the count's maximum.
  function automatic logic [COUNT_W-1:0] sat_mul(input logic [COUNT_W-1:0] total,
                                                 input logic [EXP_W-1:0]   factor);
    logic [COUNT_W+EXP_W-1:0] prod;
    prod = (COUNT_W + EXP_W)'(total) * (COUNT_W + EXP_W)'(factor);
    if (prod > (COUNT_W + EXP_W)'({COUNT_W{1'b1}})) begin
      return {COUNT_W{1'b1}};
    end
    return prod[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/sieve_divisor_counter_unit.sv -----
`default_nettype none

// Divisor counter built on a largest-prime-factor table.
// The request channel (req_valid, req_stall, command, value) takes one word at
// a time. A build word clears the factor table and runs the sieve over it; a
// query word factors value through table lookups and returns its divisor count.
// Every request word gives exactly one response word on (rsp_valid, rsp_stall,
// divisor_count, status), in order.
// A build makes one clearing write per entry, a read and check per index, and
// one write per multiple of each prime. A query for values 0 and 1, or one
// in error, goes straight to the output; otherwise each prime factor found,
// counted with multiplicity, costs one table read plus a restoring divide
// over IDX_W bits.
// Only one request is in work at a time. A finished response sits in the
// output register; the next request is accepted meanwhile, and its result
// waits until the output register is free while rsp_stall is high.
// Reset clears the built flag, so queries report status 2 until a build has
// run; the table contents themselves are not cleared by reset.

module sieve_divisor_counter_unit
  import sdc_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_stall,
  input  wire                  command,
  input  wire [VAL_W-1:0]      value,
  output logic                 rsp_valid,
  input  wire                  rsp_stall,
  output logic [COUNT_W-1:0]   divisor_count,
  output logic [STATUS_W-1:0]  status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SV_RD,
    S_SV_CHK,
    S_SV_MARK,
    S_Q_RD,
    S_Q_CHK,
    S_DIV,
    S_Q_FIN,
    S_OUT
  } state_t;

  state_t               state;
  logic                 table_ready;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     j;
  logic [IDX_W-1:0]     n;
  logic [FAC_W-1:0]     cur_p;
  logic [EXP_W-1:0]     exp_cnt;
  logic [COUNT_W-1:0]   total;
  logic [IDX_W-1:0]     dvd;
  logic [IDX_W-1:0]     rem;
  logic [STEP_W-1:0]    step;
  logic [COUNT_W-1:0]   res_count;
  logic [STATUS_W-1:0]  res_status;

  logic [FAC_W-1:0]     factor_table [TABLE_SIZE];
  logic [FAC_W-1:0]     rd_data;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [FAC_W-1:0]     mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;

  logic                 req_take;
  logic                 out_free;
  logic [CNT_W-1:0]     idx_next;
  logic [CNT_W-1:0]     j_next;
  logic [IDX_W:0]       rem_sh;
  logic                 sub_ok;
  logic [IDX_W:0]       rem_new;
  logic [IDX_W-1:0]     quo_new;
  logic [COUNT_W-1:0]   total_next;
  logic                 q_small;
  logic                 out_of_range;

  assign req_stall    = (state != S_IDLE);
  assign req_take     = req_valid && !req_stall;
  assign out_free     = !rsp_valid || !rsp_stall;
  assign idx_next     = idx + CNT_W'(1);
  assign j_next       = j + idx;
  assign out_of_range = ({1'b0, value} >= (VAL_W + 1)'(TABLE_SIZE));
  assign q_small      = (rd_data < FAC_W'(2));
  assign total_next   = sat_mul(total, exp_cnt + EXP_W'(1));

  // One restoring division step: the quotient bits shift into dvd.
  assign rem_sh  = {rem, dvd[IDX_W-1]};
  assign sub_ok  = (rem_sh >= {1'b0, cur_p});
  assign rem_new = sub_ok ? (rem_sh - {1'b0, cur_p}) : rem_sh;
  assign quo_new = {dvd[IDX_W-2:0], sub_ok};

  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_SV_MARK);
    mem_waddr = (state == S_CLEAR) ? idx[IDX_W-1:0] : j[IDX_W-1:0];
    if (state == S_CLEAR) begin
      mem_wdata = (idx < CNT_W'(2)) ? FAC_W'(1) : FAC_W'(0);
    end else begin
      mem_wdata = idx[FAC_W-1:0];
    end
    mem_raddr = (state == S_SV_RD) ? idx[IDX_W-1:0] : n;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      factor_table[mem_waddr] <= mem_wdata;
    end
    rd_data <= factor_table[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      table_ready <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      // A response word loaded from S_OUT in this cycle keeps valid high.
      if (rsp_valid && !rsp_stall && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            if (command == CMD_BUILD) begin
              idx   <= '0;
              state <= S_CLEAR;
            end else if (!table_ready) begin
              res_count  <= '0;
              res_status <= ST_NOT_BUILT;
              state      <= S_OUT;
            end else if (out_of_range) begin
              res_count  <= '0;
              res_status <= ST_RANGE;
              state      <= S_OUT;
            end else if (value < VAL_W'(2)) begin
              res_count  <= COUNT_W'(1);
              res_status <= ST_OK;
              state      <= S_OUT;
            end else begin
              n       <= value[IDX_W-1:0];
              total   <= COUNT_W'(1);
              exp_cnt <= '0;
              state   <= S_Q_RD;
            end
          end
        end
        S_CLEAR: begin
          if (idx == CNT_W'(TABLE_SIZE - 1)) begin
            idx   <= CNT_W'(2);
            state <= S_SV_RD;
          end else begin
            idx <= idx_next;
          end
        end
        S_SV_RD: begin
          state <= S_SV_CHK;
        end
        S_SV_CHK: begin
          // An entry still zero was reached by no smaller prime.
          if (rd_data == '0) begin
            j     <= idx;
            state <= S_SV_MARK;
          end else if (idx_next == CNT_W'(TABLE_SIZE)) begin
            table_ready <= 1'b1;
            res_count   <= '0;
            res_status  <= ST_OK;
            state       <= S_OUT;
          end else begin
            idx   <= idx_next;
            state <= S_SV_RD;
          end
        end
        S_SV_MARK: begin
          if (j_next < CNT_W'(TABLE_SIZE)) begin
            j <= j_next;
          end else if (idx_next == CNT_W'(TABLE_SIZE)) begin
            table_ready <= 1'b1;
            res_count   <= '0;
            res_status  <= ST_OK;
            state       <= S_OUT;
          end else begin
            idx   <= idx_next;
            state <= S_SV_RD;
          end
        end
        S_Q_RD: begin
          state <= S_Q_CHK;
        end
        S_Q_CHK: begin
          // Same prime as before: divide again. Otherwise close out the
          // previous prime and start on the one just read.
          if (exp_cnt != '0 && rd_data == cur_p) begin
            dvd   <= n;
            rem   <= '0;
            step  <= '0;
            state <= S_DIV;
          end else begin
            total   <= total_next;
            exp_cnt <= '0;
            if (q_small) begin
              res_count  <= total_next;
              res_status <= ST_OK;
              state      <= S_OUT;
            end else begin
              cur_p <= rd_data;
              dvd   <= n;
              rem   <= '0;
              step  <= '0;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          dvd  <= quo_new;
          rem  <= rem_new[IDX_W-1:0];
          step <= step + STEP_W'(1);
          if (step == STEP_W'(IDX_W - 1)) begin
            exp_cnt <= exp_cnt + EXP_W'(1);
            n       <= quo_new;
            if (quo_new == IDX_W'(1)) begin
              state <= S_Q_FIN;
            end else begin
              state <= S_Q_RD;
            end
          end
        end
        S_Q_FIN: begin
          res_count  <= total_next;
          res_status <= ST_OK;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            divisor_count <= res_count;
            status        <= res_status;
            rsp_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_not_built_reported: assert property (@(posedge clk) disable iff (rst)
    (req_take && command == CMD_QUERY && !table_ready)
      |=> (state == S_OUT && res_status == ST_NOT_BUILT))
    else $error("query before build did not report not-built status");

  a_error_zero_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_OK) |-> (divisor_count == '0))
    else $error("error response carries a nonzero count");

  a_divisor_prime: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cur_p >= FAC_W'(2)))
    else $error("division started with a divisor below two");

  a_query_needs_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_RD || state == S_Q_CHK) |-> table_ready)
    else $error("table lookup for a query without a built table");

  a_no_write_on_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_RD || state == S_Q_CHK || state == S_DIV) |-> !mem_we)
    else $error("table written during a query");

endmodule

`default_nettype wire

// ----- bench/sieve_divisor_counter_checker.sv -----
`timescale 1ns / 100ps

module sieve_divisor_counter_checker
  import sdc_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  input  wire                 req_stall,
  input  wire                 command,
  input  wire [VAL_W-1:0]     value,
  input  wire                 rsp_valid,
  input  wire                 rsp_stall,
  input  wire [COUNT_W-1:0]   divisor_count,
  input  wire [STATUS_W-1:0]  status,
  output int                  mismatches,
  output int                  awaited,
  output int                  answered
);

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] st;
  } answer_t;

  answer_t answers_due[$];
  bit      table_built = 1'b0;
  int      bad_words = 0;
  int      good_words = 0;

  // Divisor count by trial division: product of (exponent + 1), saturated.
  function automatic logic [COUNT_W-1:0] divisors_of(input logic [VAL_W-1:0] v);
    int unsigned n;
    int unsigned p;
    int unsigned e;
    int unsigned total;
    n = 32'(v);
    total = 1;
    for (p = 2; p * p <= n; p++) begin
      if (n % p == 0) begin
        e = 0;
        while (n % p == 0) begin
          n = n / p;
          e++;
        end
        total = total * (e + 1);
        if (total > 255) total = 255;
      end
    end
    if (n > 1) total = total * 2;
    if (total > 255) total = 255;
    return total[COUNT_W-1:0];
  endfunction

  function automatic answer_t answer_for(input logic cmd, input logic [VAL_W-1:0] v,
                                         input bit built);
    answer_t a;
    a.count = '0;
    a.st = ST_OK;
    if (cmd == CMD_BUILD) begin
      a.st = ST_OK;
    end else if (!built) begin
      a.st = ST_NOT_BUILT;
    end else if (v >= TABLE_SIZE) begin
      a.st = ST_RANGE;
    end else begin
      a.count = divisors_of(v);
    end
    return a;
  endfunction

  // Appends an expected answer behind those already waiting.
  function automatic void queue_answer(input answer_t a);
    answers_due.insert(answers_due.size(), a);
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      answers_due.delete();
      table_built = 1'b0;
    end else begin
      // The request is predicted first so that the queue order follows acceptance order.
      if (req_valid && !req_stall) begin
        queue_answer(answer_for(command, value, table_built));
        if (command == CMD_BUILD) table_built = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
        if (answers_due.size() == 0) begin
          bad_words++;
          $error("response word with no request outstanding: divisor_count %0d status %0d",
                 divisor_count, status);
        end else begin
          want = answers_due.pop_front();
          good_words++;
          if (divisor_count !== want.count) begin
            bad_words++;
            $error("divisor_count: expected %0d, actual %0d", want.count, divisor_count);
          end
          if (status !== want.st) begin
            bad_words++;
            $error("status: expected %0d, actual %0d", want.st, status);
          end
        end
      end
    end
    mismatches <= bad_words;
    awaited <= answers_due.size();
    answered <= good_words;
  end

endmodule

// ----- bench/sieve_divisor_counter_unit_tb.sv -----
`timescale 1ns / 100ps

module sieve_divisor_counter_unit_tb
  import sdc_pkg::*;
();

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               command = CMD_QUERY;
  logic [VAL_W-1:0]   value = '0;
  logic               rsp_stall = 1'b0;
  wire                req_stall;
  wire                rsp_valid;
  wire [COUNT_W-1:0]  divisor_count;
  wire [STATUS_W-1:0] status;

  int mismatches;
  int awaited;
  int answered;
  int idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;

  sieve_divisor_counter_unit dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .command       (command),
    .value         (value),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .divisor_count (divisor_count),
    .status        (status)
  );

  sieve_divisor_counter_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .command       (command),
    .value         (value),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .divisor_count (divisor_count),
    .status        (status),
    .mismatches    (mismatches),
    .awaited       (awaited),
    .answered      (answered)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // The timeout leaves ample margin for two full builds.
  initial begin
    #500000000;
    $display("sieve_divisor_counter_unit_tb: done, errors");
    $finish;
  end

  // Offers one request word and returns at the edge where it is accepted.
  task automatic send_word(input logic cmd, input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    command <= cmd;
    value <= v;
    do @(posedge clk); while (req_stall);
    words_sent++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned v;
    int unsigned p;
    v = 1;
    case ($urandom_range(9))
      0: v = $urandom_range(40);
      1: v = $urandom_range(TABLE_SIZE, (1 << VAL_W) - 1);
      2, 3: begin
        // Smooth numbers have many prime factors and long factoring runs.
        repeat ($urandom_range(1, 20)) begin
          case ($urandom_range(5))
            0: p = 2;
            1: p = 3;
            2: p = 5;
            3: p = 7;
            4: p = 11;
            default: p = 13;
          endcase
          if (v * p < TABLE_SIZE) v = v * p;
        end
      end
      default: v = $urandom_range(TABLE_SIZE - 1);
    endcase
    return v[VAL_W-1:0];
  endfunction

  initial begin
    int idle_mix[4];
    int stall_mix[4];
    idle_mix = '{0, 57, 0, 37};
    stall_mix = '{0, 0, 57, 37};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Queries ahead of any build report the table as not built.
    send_word(CMD_QUERY, VAL_W'(0));
    send_word(CMD_QUERY, VAL_W'(1));
    send_word(CMD_QUERY, VAL_W'(TABLE_SIZE));
    send_word(CMD_QUERY, VAL_W'((1 << VAL_W) - 1));
    send_word(CMD_BUILD, VAL_W'((1 << VAL_W) - 1));
    send_word(CMD_QUERY, VAL_W'(0));
    send_word(CMD_QUERY, VAL_W'(1));
    send_word(CMD_QUERY, VAL_W'(2));
    send_word(CMD_QUERY, VAL_W'(3));
    send_word(CMD_QUERY, VAL_W'(4));
    send_word(CMD_QUERY, VAL_W'(12));
    send_word(CMD_QUERY, VAL_W'(262144));
    send_word(CMD_QUERY, VAL_W'(498960));
    send_word(CMD_QUERY, VAL_W'(TABLE_SIZE - 1));
    send_word(CMD_QUERY, VAL_W'(TABLE_SIZE - 2));
    send_word(CMD_QUERY, VAL_W'(TABLE_SIZE));
    send_word(CMD_QUERY, VAL_W'((1 << VAL_W) - 1));
    send_word(CMD_QUERY, VAL_W'(720720));
    // A second build must leave the same table behind.
    send_word(CMD_BUILD, VAL_W'(0));
    send_word(CMD_QUERY, VAL_W'(360360));
    send_word(CMD_QUERY, VAL_W'(1));
    send_word(CMD_QUERY, VAL_W'(97));

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_mix[ph];
      stall_pct = stall_mix[ph];
      repeat (225) send_word(CMD_QUERY, pick_value());
    end
    req_valid <= 1'b0;

    // The checker's count includes the last word only after one more edge.
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (500) @(posedge clk);

    $display("%0d request words sent and %0d response words checked", words_sent, answered);
    $display("covered: pre-build queries, two table builds, range errors, four idle mixes");
    if (mismatches == 0 && awaited == 0) begin
      $display("sieve_divisor_counter_unit_tb: done, clean");
    end else begin
      $display("sieve_divisor_counter_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sieve_divisor_counter_unit.f -----
src/sdc_pkg.sv
src/sieve_divisor_counter_unit.sv
bench/sieve_divisor_counter_checker.sv
bench/sieve_divisor_counter_unit_tb.sv
